/* hdl/qrm_pkg.sv */
`timescale 1ns / 1ps

package qrm_pkg;

    // Field and matrix geometry
    localparam int Q_W    = 16;          // component and matrix entry width
    localparam int NLANE  = 9;           // matrix entries, row major
    localparam int QBITS  = 15;          // quotient bits, covers 0..16384
    localparam int PROD_W = 32;          // 16x16 signed product
    localparam int LEN_W  = 33;          // squared length, up to 2^32
    localparam int SUM_W  = 33;          // signed sum of two products
    localparam int NUM_W  = 35;          // signed numerator, |N| <= len2
    localparam int MAG_W  = 33;          // numerator magnitude
    localparam int DEN_W  = 34;          // doubled squared length
    localparam int REM_W  = 34;          // partial remainder, always below DEN

    // Pipeline depth
    localparam int FRONT_STAGES = 3;     // products, sums, numerators
    localparam int DIV_STAGES   = QBITS; // one quotient bit per stage
    localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + 1;

    // 1.0 in Q2.14
    localparam logic [Q_W-1:0] Q_ONE = 16'h4000;

    // Entries on the main diagonal (m00, m11, m22)
    localparam logic [NLANE-1:0] DIAG_MASK = 9'b100_010_001;

    // Entry positions
    localparam int L_M00 = 0;
    localparam int L_M01 = 1;
    localparam int L_M02 = 2;
    localparam int L_M10 = 3;
    localparam int L_M11 = 4;
    localparam int L_M12 = 5;
    localparam int L_M20 = 6;
    localparam int L_M21 = 7;
    localparam int L_M22 = 8;

    // Nine Q2.14 entries, m00 in the lowest bits
    typedef logic [NLANE-1:0][Q_W-1:0] matrix_t;

    // Front end to divider
    typedef struct packed {
        logic [NLANE-1:0][REM_W-1:0] ahi;   // dividend upper part, mag + len2>>15
        logic [NLANE-1:0]            neg;   // numerator sign
        logic [DEN_W-1:0]            den;   // 2*len2
        logic [QBITS-1:0]            alo;   // dividend lower bits, len2[14:0]
        logic                        zero;  // len2 == 0
    } div_in_t;

    // Divider to output stage
    typedef struct packed {
        logic [NLANE-1:0][QBITS-1:0] quo;
        logic [NLANE-1:0]            neg;
        logic                        zero;
    } div_out_t;

endpackage

/* hdl/qrm_front.sv */
`timescale 1ns / 1ps

module qrm_front (
    input  logic                                 clk,
    input  logic [qrm_pkg::FRONT_STAGES-1:0]     en,
    input  logic signed [qrm_pkg::Q_W-1:0]       qx,
    input  logic signed [qrm_pkg::Q_W-1:0]       qy,
    input  logic signed [qrm_pkg::Q_W-1:0]       qz,
    input  logic signed [qrm_pkg::Q_W-1:0]       qw,
    output qrm_pkg::div_in_t                     dout
);
    import qrm_pkg::*;

    // Stage 0: all ten products
    logic signed [PROD_W-1:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [PROD_W-1:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            ww_reg <= qw * qw;
            xy_reg <= qx * qy;
            xz_reg <= qx * qz;
            yz_reg <= qy * qz;
            wx_reg <= qw * qx;
            wy_reg <= qw * qy;
            wz_reg <= qw * qz;
        end
    end

    // Stage 1: squared length, square pairs, product sums
    logic [LEN_W-1:0]        len2_reg;
    logic [PROD_W-1:0]       sq_yz_reg, sq_xz_reg, sq_xy_reg;
    logic signed [SUM_W-1:0] s01_reg, s02_reg, s10_reg, s12_reg, s20_reg, s21_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            // squares are nonnegative and below 2^31
            len2_reg  <= {2'b00, xx_reg[PROD_W-2:0]} + {2'b00, yy_reg[PROD_W-2:0]}
                       + {2'b00, zz_reg[PROD_W-2:0]} + {2'b00, ww_reg[PROD_W-2:0]};
            sq_yz_reg <= {1'b0, yy_reg[PROD_W-2:0]} + {1'b0, zz_reg[PROD_W-2:0]};
            sq_xz_reg <= {1'b0, xx_reg[PROD_W-2:0]} + {1'b0, zz_reg[PROD_W-2:0]};
            sq_xy_reg <= {1'b0, xx_reg[PROD_W-2:0]} + {1'b0, yy_reg[PROD_W-2:0]};
            s01_reg   <= SUM_W'(xy_reg) + SUM_W'(wz_reg);
            s02_reg   <= SUM_W'(xz_reg) - SUM_W'(wy_reg);
            s10_reg   <= SUM_W'(xy_reg) - SUM_W'(wz_reg);
            s12_reg   <= SUM_W'(yz_reg) + SUM_W'(wx_reg);
            s20_reg   <= SUM_W'(xz_reg) + SUM_W'(wy_reg);
            s21_reg   <= SUM_W'(yz_reg) - SUM_W'(wx_reg);
        end
    end

    // Stage 2: signed numerators, magnitude and dividend split
    logic signed [NUM_W-1:0] num [NLANE];
    logic [NUM_W-1:0]        mag_full [NLANE];
    div_in_t                 dout_next;
    div_in_t                 dout_reg;

    function automatic logic signed [NUM_W-1:0] diag_num(input logic [LEN_W-1:0] len2,
                                                        input logic [PROD_W-1:0] sq);
        return signed'({2'b00, len2}) - signed'({2'b00, sq, 1'b0});
    endfunction

    function automatic logic signed [NUM_W-1:0] off_num(input logic signed [SUM_W-1:0] s);
        return signed'({s[SUM_W-1], s, 1'b0});
    endfunction

    always_comb
    begin
        num[L_M00] = diag_num(len2_reg, sq_yz_reg);
        num[L_M01] = off_num(s01_reg);
        num[L_M02] = off_num(s02_reg);
        num[L_M10] = off_num(s10_reg);
        num[L_M11] = diag_num(len2_reg, sq_xz_reg);
        num[L_M12] = off_num(s12_reg);
        num[L_M20] = off_num(s20_reg);
        num[L_M21] = off_num(s21_reg);
        num[L_M22] = diag_num(len2_reg, sq_xy_reg);

        dout_next.den  = {len2_reg, 1'b0};
        dout_next.alo  = len2_reg[QBITS-1:0];
        dout_next.zero = (len2_reg == '0);
        for (int l = 0; l < NLANE; l++)
        begin
            dout_next.neg[l] = num[l][NUM_W-1];
            mag_full[l]      = num[l][NUM_W-1] ? -num[l] : num[l];
            // A = mag*2^15 + len2 split as ahi*2^15 + alo
            dout_next.ahi[l] = {1'b0, mag_full[l][MAG_W-1:0]}
                             + {{(REM_W-LEN_W+QBITS){1'b0}}, len2_reg[LEN_W-1:QBITS]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

/* hdl/qrm_divider.sv */
`timescale 1ns / 1ps

module qrm_divider (
    input  logic                               clk,
    input  logic [qrm_pkg::DIV_STAGES-1:0]     en,
    input  qrm_pkg::div_in_t                   din,
    output qrm_pkg::div_out_t                  dout
);
    import qrm_pkg::*;

    // Per-stage registers, nine lanes share divisor and low dividend bits
    logic [REM_W-1:0] rem_reg  [DIV_STAGES][NLANE];
    logic [QBITS-1:0] quo_reg  [DIV_STAGES][NLANE];
    logic [DEN_W-1:0] den_reg  [DIV_STAGES];
    logic [QBITS-1:0] alo_reg  [DIV_STAGES];
    logic [NLANE-1:0] neg_reg  [DIV_STAGES];
    logic             zero_reg [DIV_STAGES];

    logic [REM_W-1:0] rem_src  [DIV_STAGES][NLANE];
    logic [QBITS-1:0] quo_src  [DIV_STAGES][NLANE];
    logic [DEN_W-1:0] den_src  [DIV_STAGES];
    logic [QBITS-1:0] alo_src  [DIV_STAGES];
    logic [NLANE-1:0] neg_src  [DIV_STAGES];
    logic             zero_src [DIV_STAGES];

    logic [REM_W-1:0] rem_next [DIV_STAGES][NLANE];
    logic [QBITS-1:0] quo_next [DIV_STAGES][NLANE];

    // One restoring step: shift in one dividend bit, subtract if it fits
    function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                                input logic             din_bit,
                                                input logic [DEN_W-1:0] den);
        logic [REM_W:0] trial;
        logic [REM_W:0] diff;
        trial = {rem, din_bit};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den})
            return {1'b1, diff[REM_W-1:0]};
        else
            return {1'b0, trial[REM_W-1:0]};
    endfunction

    // Stage inputs
    always_comb
    begin
        den_src[0]  = din.den;
        alo_src[0]  = din.alo;
        neg_src[0]  = din.neg;
        zero_src[0] = din.zero;
        for (int l = 0; l < NLANE; l++)
        begin
            rem_src[0][l] = din.ahi[l];
            quo_src[0][l] = '0;
        end
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            den_src[k]  = den_reg[k-1];
            alo_src[k]  = alo_reg[k-1];
            neg_src[k]  = neg_reg[k-1];
            zero_src[k] = zero_reg[k-1];
            for (int l = 0; l < NLANE; l++)
            begin
                rem_src[k][l] = rem_reg[k-1][l];
                quo_src[k][l] = quo_reg[k-1][l];
            end
        end
    end

    // Quotient bit per stage, MSB first
    always_comb
    begin
        logic [REM_W:0] res;
        res = '0;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                res            = div_step(rem_src[k][l], alo_src[k][QBITS-1], den_src[k]);
                rem_next[k][l] = res[REM_W-1:0];
                quo_next[k][l] = {quo_src[k][l][QBITS-2:0], res[REM_W]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (en[k])
            begin
                den_reg[k]  <= den_src[k];
                alo_reg[k]  <= {alo_src[k][QBITS-2:0], 1'b0};
                neg_reg[k]  <= neg_src[k];
                zero_reg[k] <= zero_src[k];
                for (int l = 0; l < NLANE; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    quo_reg[k][l] <= quo_next[k][l];
                end
            end
        end
    end

    // Final quotients
    always_comb
    begin
        dout.neg  = neg_reg[DIV_STAGES-1];
        dout.zero = zero_reg[DIV_STAGES-1];
        for (int l = 0; l < NLANE; l++)
        begin
            dout.quo[l] = quo_reg[DIV_STAGES-1][l];
        end
    end

endmodule

/* hdl/quaternion_to_rotation_matrix.sv */
`timescale 1ns / 1ps
// Quaternion to 3x3 rotation matrix, Q2.14 (16384 = 1.0).
// Input stream (s_axis): one quaternion per transfer, four signed 16-bit
// components on any common scale. Output stream (m_axis): nine signed
// Q2.14 entries m00..m22 in row-major order, plus a flag in tuser that is
// set when all components are zero; the identity matrix is then given.
// Every entry is round-to-nearest (ties away from zero) of N*16384/len2,
// with no square root; the quotient comes from a 15-step restoring divider.
// Pipeline: 19 register stages (products, sums, numerators, 15 divider
// steps, output). Throughput: one quaternion per cycle, sustained while
// m_axis_tready is high.
// Each stage carries a valid bit and loads whenever it is empty or the
// stage after it moves, so when m_axis_tready is low the pipeline keeps
// taking input until it fills up; bubbles are squeezed out and nothing is
// lost or duplicated. s_axis_tready is high whenever m_axis_tready is.
// Reset (rst_n low, asynchronous) clears all valid bits; no item survives.
// No state is kept between quaternions.
module quaternion_to_rotation_matrix (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // qx, qy, qz, qw
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic         m_axis_tuser    // zero_length
);
    import qrm_pkg::*;

    localparam int OUT_STAGE = PIPE_STAGES - 1;

    // Stage valid bits and load enables
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES-1:0] stage_en;

    always_comb
    begin
        stage_en[OUT_STAGE] = !valid_reg[OUT_STAGE] || m_axis_tready;
        for (int i = OUT_STAGE - 1; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
            valid_next[0] = s_axis_tvalid;
        for (int i = 1; i < PIPE_STAGES; i++)
        begin
            if (stage_en[i])
                valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign s_axis_tready = stage_en[0];
    assign m_axis_tvalid = valid_reg[OUT_STAGE];

    // Products through numerators
    div_in_t  front_out;
    div_out_t div_out;

    qrm_front u_front (
        .clk  (clk),
        .en   (stage_en[FRONT_STAGES-1:0]),
        .qx   (signed'(s_axis_tdata[15:0])),
        .qy   (signed'(s_axis_tdata[31:16])),
        .qz   (signed'(s_axis_tdata[47:32])),
        .qw   (signed'(s_axis_tdata[63:48])),
        .dout (front_out)
    );

    // Shared-divisor restoring divider, nine lanes
    qrm_divider u_divider (
        .clk  (clk),
        .en   (stage_en[FRONT_STAGES +: DIV_STAGES]),
        .din  (front_out),
        .dout (div_out)
    );

    // Output stage: apply sign, substitute identity for zero length
    matrix_t mat_next;
    matrix_t mat_reg;
    logic    zero_reg;

    always_comb
    begin
        for (int l = 0; l < NLANE; l++)
        begin
            if (div_out.zero)
                mat_next[l] = DIAG_MASK[l] ? Q_ONE : '0;
            else if (div_out.neg[l])
                mat_next[l] = -{1'b0, div_out.quo[l]};
            else
                mat_next[l] = {1'b0, div_out.quo[l]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[OUT_STAGE])
        begin
            mat_reg  <= mat_next;
            zero_reg <= div_out.zero;
        end
    end

    assign m_axis_tdata = mat_reg;
    assign m_axis_tuser = zero_reg;

endmodule

/* hdl/qrm_checker.sv */
`timescale 1ns / 1ps

module qrm_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tready,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [143:0] m_axis_tdata,
    input  logic         m_axis_tuser
);
    import qrm_pkg::*;

    // m22 on top, m00 at the bottom
    localparam logic [143:0] IDENTITY = {Q_ONE, 48'h0, Q_ONE, 48'h0, Q_ONE};

    // A ready sink never holds back the source
    a_ready_passes: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("s_axis_tready low while m_axis_tready high");

    // Zero-length flag comes with the identity matrix
    a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == IDENTITY)
        else $error("zero_length result is not the identity matrix");

    // A stalled result stays offered
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("m_axis_tvalid dropped during stall");

    // A stalled result keeps its payload
    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("m_axis payload changed during stall");

endmodule

bind quaternion_to_rotation_matrix qrm_checker u_qrm_checker (.*);
